@@ rtl/assert_macros.svh @@
// Assertion macros for the checker file of the console writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCCW_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |-> (cons)) else $error("console writer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) \
        (ante) |=> (cons)) else $error("console writer check failed");

`endif

@@ rtl/tccw_pkg.sv @@
// Shared constants, types and control structs of the text console writer.
package tccw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int INDEX_W = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int BYTE_W  = 8;
    localparam int CELL_W  = 16;

    localparam logic [COL_W:0]     COL_LIMIT   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]     ROW_LIMIT   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]   LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [INDEX_W:0]   CELL_LIMIT  = (INDEX_W + 1)'(CELL_COUNT);
    localparam logic [INDEX_W-1:0] LAST_CELL   = INDEX_W'(CELL_COUNT - 1);
    localparam logic [INDEX_W-1:0] BLANK_START = INDEX_W'((ROWS - 1) * COLUMNS);
    localparam logic [INDEX_W-1:0] COLUMNS_IDX = INDEX_W'(COLUMNS);

    localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'h0A;
    localparam logic [BYTE_W-1:0] SPACE_CODE      = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_ATTRIBUTE = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL      = {RESET_ATTRIBUTE, SPACE_CODE};

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RESP,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic init_write;
        logic copy_read;
        logic blank_write;
        logic ptr_load_copy;
        logic ptr_load_blank;
        logic load_out;
        logic out_from_next;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_put;
        logic scroll_now;
        logic slot_free;
        logic ptr_last;
    } ctrl_status_t;

endpackage

@@ rtl/tccw_ctrl.sv @@
// Controller state machine of the text console writer.
module tccw_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  tccw_pkg::ctrl_status_t status,
    output logic                  cmd_stall,
    output tccw_pkg::ctrl_cmd_t    ctrl
);

    tccw_pkg::state_t state_reg;
    tccw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tccw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                if (status.ptr_last)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC:
            begin
                if (status.is_put && status.scroll_now)
                begin
                    state_next = tccw_pkg::ST_COPY;
                end
                else if (status.slot_free)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tccw_pkg::ST_RESP;
                end
            end
            tccw_pkg::ST_RESP:
            begin
                if (status.slot_free)
                begin
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_COPY:
            begin
                if (status.ptr_last)
                begin
                    state_next = tccw_pkg::ST_DRAIN;
                end
            end
            tccw_pkg::ST_DRAIN:
            begin
                state_next = tccw_pkg::ST_BLANK;
            end
            tccw_pkg::ST_BLANK:
            begin
                if (status.ptr_last)
                begin
                    state_next = tccw_pkg::ST_RESP;
                end
            end
            default:
            begin
                state_next = tccw_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        cmd_stall = 1'b1;
        unique case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                ctrl.init_write = 1'b1;
            end
            tccw_pkg::ST_IDLE:
            begin
                cmd_stall    = 1'b0;
                ctrl.capture = cmd_valid;
            end
            tccw_pkg::ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (status.is_put && status.scroll_now)
                begin
                    ctrl.ptr_load_copy = 1'b1;
                end
                else if (status.slot_free)
                begin
                    ctrl.load_out      = 1'b1;
                    ctrl.out_from_next = 1'b1;
                end
            end
            tccw_pkg::ST_RESP:
            begin
                ctrl.load_out = status.slot_free;
            end
            tccw_pkg::ST_COPY:
            begin
                ctrl.copy_read = 1'b1;
            end
            tccw_pkg::ST_DRAIN:
            begin
                ctrl.ptr_load_blank = 1'b1;
            end
            tccw_pkg::ST_BLANK:
            begin
                ctrl.blank_write = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

@@ rtl/tccw_datapath.sv @@
// Datapath of the text console writer: cell memory, cursor, pointer and result register.
module tccw_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tccw_pkg::ctrl_cmd_t            ctrl,
    output tccw_pkg::ctrl_status_t         status,
    input  logic                          cfg_write_enable,
    input  logic [tccw_pkg::BYTE_W-1:0]   cfg_write_data,
    input  logic                          command,
    input  logic [tccw_pkg::BYTE_W-1:0]   char_code,
    input  logic [tccw_pkg::BYTE_W-1:0]   color,
    input  logic [tccw_pkg::INDEX_W-1:0]  read_index,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [tccw_pkg::COL_W-1:0]    cursor_col,
    output logic [tccw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tccw_pkg::CELL_W-1:0]   cell_data,
    output logic                          scrolled
);

    logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELL_COUNT];

    logic [tccw_pkg::BYTE_W-1:0]  blank_attr_reg;
    logic [tccw_pkg::COL_W-1:0]   col_reg;
    logic [tccw_pkg::ROW_W-1:0]   row_reg;
    logic [tccw_pkg::INDEX_W-1:0] ptr_reg;
    logic [tccw_pkg::INDEX_W-1:0] ptr_next;
    logic                         copy_wr_valid_reg;
    logic [tccw_pkg::INDEX_W-1:0] copy_wr_addr_reg;
    logic [tccw_pkg::CELL_W-1:0]  rd_data_reg;
    logic                         command_reg;
    logic [tccw_pkg::BYTE_W-1:0]  char_code_reg;
    logic [tccw_pkg::BYTE_W-1:0]  color_reg;
    logic                         read_ok_reg;
    logic                         scrolled_reg;
    logic                         rsp_valid_reg;
    logic [tccw_pkg::COL_W-1:0]   out_col_reg;
    logic [tccw_pkg::ROW_W-1:0]   out_row_reg;
    logic [tccw_pkg::CELL_W-1:0]  out_cell_reg;
    logic                         out_scrolled_reg;

    logic                         read_in_range;
    logic                         is_put;
    logic                         is_newline;
    logic [tccw_pkg::COL_W:0]     col_inc;
    logic [tccw_pkg::ROW_W:0]     row_inc;
    logic                         wrap;
    logic                         row_over;
    logic [tccw_pkg::COL_W-1:0]   col_next;
    logic [tccw_pkg::ROW_W-1:0]   row_next;
    logic                         scroll_now;
    logic [tccw_pkg::INDEX_W-1:0] put_addr;
    logic [tccw_pkg::CELL_W-1:0]  result_cell;

    logic                         mem_we;
    logic [tccw_pkg::INDEX_W-1:0] mem_waddr;
    logic [tccw_pkg::CELL_W-1:0]  mem_wdata;
    logic                         mem_re;
    logic [tccw_pkg::INDEX_W-1:0] mem_raddr;

    assign read_in_range = {1'b0, read_index} < tccw_pkg::CELL_LIMIT;
    assign is_put        = (command_reg == tccw_pkg::CMD_PUT);
    assign is_newline    = (char_code_reg == tccw_pkg::NEWLINE_CODE);

    // Cursor advance for a put; a newline or the row end both move to the next row.
    always_comb
    begin
        col_inc    = {1'b0, col_reg} + (tccw_pkg::COL_W + 1)'(1);
        row_inc    = {1'b0, row_reg} + (tccw_pkg::ROW_W + 1)'(1);
        wrap       = is_newline || (col_inc == tccw_pkg::COL_LIMIT);
        row_over   = wrap && (row_inc == tccw_pkg::ROW_LIMIT);
        col_next   = col_reg;
        row_next   = row_reg;
        scroll_now = 1'b0;
        if (is_put)
        begin
            if (row_over)
            begin
                col_next   = '0;
                row_next   = tccw_pkg::LAST_ROW;
                scroll_now = 1'b1;
            end
            else if (wrap)
            begin
                col_next = '0;
                row_next = row_inc[tccw_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[tccw_pkg::COL_W-1:0];
            end
        end
    end

    assign put_addr = tccw_pkg::INDEX_W'(tccw_pkg::INDEX_W'(row_reg) * tccw_pkg::COLUMNS_IDX)
                    + tccw_pkg::INDEX_W'(col_reg);

    assign result_cell = (!is_put && read_ok_reg) ? rd_data_reg : '0;

    // One write port: clearing sweep, put, pipelined copy write-back and blanking.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = tccw_pkg::RESET_CELL;
        if (ctrl.init_write)
        begin
            mem_we = 1'b1;
        end
        else if (ctrl.exec && is_put && !is_newline)
        begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = {color_reg, char_code_reg};
        end
        else if (copy_wr_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_wr_addr_reg;
            mem_wdata = rd_data_reg;
        end
        else if (ctrl.blank_write)
        begin
            mem_we    = 1'b1;
            mem_wdata = {blank_attr_reg, tccw_pkg::SPACE_CODE};
        end
    end

    assign mem_re    = ctrl.copy_read
                     || (ctrl.capture && (command == tccw_pkg::CMD_READ) && read_in_range);
    assign mem_raddr = ctrl.capture ? read_index : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctrl.ptr_load_copy)
        begin
            ptr_next = tccw_pkg::COLUMNS_IDX;
        end
        else if (ctrl.ptr_load_blank)
        begin
            ptr_next = tccw_pkg::BLANK_START;
        end
        else if (ctrl.init_write || ctrl.copy_read || ctrl.blank_write)
        begin
            ptr_next = ptr_reg + tccw_pkg::INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_attr_reg    <= tccw_pkg::RESET_ATTRIBUTE;
            col_reg           <= '0;
            row_reg           <= '0;
            ptr_reg           <= '0;
            copy_wr_valid_reg <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                blank_attr_reg <= cfg_write_data;
            end
            if (ctrl.exec)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            ptr_reg           <= ptr_next;
            copy_wr_valid_reg <= ctrl.copy_read;
            if (ctrl.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_wr_addr_reg <= ptr_reg - tccw_pkg::COLUMNS_IDX;
        if (ctrl.capture)
        begin
            command_reg   <= command;
            char_code_reg <= char_code;
            color_reg     <= color;
            read_ok_reg   <= read_in_range;
        end
        if (ctrl.exec)
        begin
            scrolled_reg <= scroll_now;
        end
        if (ctrl.load_out)
        begin
            out_cell_reg <= result_cell;
            if (ctrl.out_from_next)
            begin
                out_col_reg      <= col_next;
                out_row_reg      <= row_next;
                out_scrolled_reg <= scroll_now;
            end
            else
            begin
                out_col_reg      <= col_reg;
                out_row_reg      <= row_reg;
                out_scrolled_reg <= scrolled_reg;
            end
        end
    end

    assign status.is_put     = is_put;
    assign status.scroll_now = scroll_now;
    assign status.slot_free  = !rsp_valid_reg || !rsp_stall;
    assign status.ptr_last   = (ptr_reg == tccw_pkg::LAST_CELL);

    assign rsp_valid  = rsp_valid_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign cell_data  = out_cell_reg;
    assign scrolled   = out_scrolled_reg;

endmodule

@@ rtl/text_console_char_writer_core.sv @@
// Top level of the text console writer: controller and datapath over an 80 x 25 cell grid.
//
//  channel   direction  handshake              payload
//  command   in         cmd_valid / cmd_stall  command, char_code, color, read_index
//  response  out        rsp_valid / rsp_stall  cursor_col, cursor_row, cell_data, scrolled
//  config    in         cfg_write_enable       cfg_write_data (blank attribute)
//
// A put or a read is taken in the idle cycle; the next cycle writes the cell or picks up
// the registered memory read and loads the response register. The memory serves one read
// and one write a cycle. A put that scrolls moves the rows up one cell a cycle through a
// pipelined read and write-back, then the bottom row is blanked. After reset the memory
// is swept to white-on-black spaces; cmd_stall stays high during the sweep, while
// configuration writes are taken as ever.
// A command may be taken while the previous response still waits under rsp_stall; the
// block then holds the new result until the response register frees up.
module text_console_char_writer_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: blank attribute used for the bottom row on a scroll.
    input  logic                          cfg_write_enable,
    input  logic [tccw_pkg::BYTE_W-1:0]   cfg_write_data,
    // Command channel.
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic                          command,
    input  logic [tccw_pkg::BYTE_W-1:0]   char_code,
    input  logic [tccw_pkg::BYTE_W-1:0]   color,
    input  logic [tccw_pkg::INDEX_W-1:0]  read_index,
    // Response channel.
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [tccw_pkg::COL_W-1:0]    cursor_col,
    output logic [tccw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tccw_pkg::CELL_W-1:0]   cell_data,
    output logic                          scrolled
);

    // Commands from the controller and status back from the datapath.
    tccw_pkg::ctrl_cmd_t    ctrl;
    tccw_pkg::ctrl_status_t status;

    // The controller sequences the clearing sweep, each command, and the scroll
    // (copy, drain of the last write-back, blanking).
    tccw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .status    (status),
        .cmd_stall (cmd_stall),
        .ctrl      (ctrl)
    );

    // The datapath owns the cell memory, the cursor, the sweep pointer and the
    // response register.
    tccw_datapath u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .status           (status),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .command          (command),
        .char_code        (char_code),
        .color            (color),
        .read_index       (read_index),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .cursor_col       (cursor_col),
        .cursor_row       (cursor_row),
        .cell_data        (cell_data),
        .scrolled         (scrolled)
    );

endmodule

@@ rtl/tccw_checker.sv @@
// Port-level checker of the text console writer and its bind to the top level.
`include "assert_macros.svh"

module tccw_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_stall,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [tccw_pkg::COL_W-1:0]    cursor_col,
    input logic [tccw_pkg::ROW_W-1:0]    cursor_row,
    input logic [tccw_pkg::CELL_W-1:0]   cell_data,
    input logic                          scrolled
);

    // A stalled response keeps its whole payload.
    `TCCW_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall,
        rsp_valid && $stable(cursor_col) && $stable(cursor_row) && $stable(cell_data) && $stable(scrolled))

    // The reported cursor always lies on the grid.
    `TCCW_ASSERT_SAME(a_cursor_on_grid, clk, rst_n, rsp_valid,
        ({1'b0, cursor_col} < tccw_pkg::COL_LIMIT) && ({1'b0, cursor_row} < tccw_pkg::ROW_LIMIT))

    // A scroll leaves the cursor at the start of the last row and reads no cell.
    `TCCW_ASSERT_SAME(a_scroll_cursor, clk, rst_n, rsp_valid && scrolled,
        (cursor_col == '0) && (cursor_row == tccw_pkg::LAST_ROW) && (cell_data == '0))

    // A take moves the controller out of idle, so the cycle after a take is stalled.
    `TCCW_ASSERT_NEXT(a_take_then_busy, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)

endmodule

bind text_console_char_writer_core tccw_checker u_tccw_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_data  (cell_data),
    .scrolled   (scrolled)
);

@@ verif/text_console_char_writer_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the text console writer core, with a class-based scoreboard.
module text_console_char_writer_core_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_ITEMS   = 360;
    localparam int CALM_ITEMS    = 50;
    // Once the last response is back the core is idle again, and quiet cycles separate the phases.
    localparam int SETTLE_CYCLES = 8;
    // Worst case: up to about 2700 transactions, each of which may scroll (about one pass
    // over the grid) and wait out the longest gap on both sides, plus the clearing sweep
    // after reset, then taken several times over.
    localparam int CYCLE_LIMIT   = 40_000_000;

    // One expected response transaction.
    typedef struct packed {
        logic [tccw_pkg::COL_W-1:0]  col;
        logic [tccw_pkg::ROW_W-1:0]  row;
        logic [tccw_pkg::CELL_W-1:0] data;
        logic                        scrolled;
    } console_result_t;

    // Scoreboard: keeps its own copy of the grid and cursor, computes the response for
    // every accepted command and checks the responses in order.
    class console_scoreboard;
        logic [tccw_pkg::CELL_W-1:0] cells [tccw_pkg::CELL_COUNT];
        int unsigned                 cur_col;
        int unsigned                 cur_row;
        logic [tccw_pkg::BYTE_W-1:0] blank_attr;
        console_result_t             expected_q[$];
        int unsigned                 mismatches;

        function new();
            foreach (cells[i])
                cells[i] = tccw_pkg::RESET_CELL;
            cur_col    = 0;
            cur_row    = 0;
            blank_attr = tccw_pkg::RESET_ATTRIBUTE;
            mismatches = 0;
        endfunction

        // Called once per accepted command transaction.
        function void note_command(logic cmd, logic [tccw_pkg::BYTE_W-1:0] ch,
                                   logic [tccw_pkg::BYTE_W-1:0] clr,
                                   logic [tccw_pkg::INDEX_W-1:0] idx);
            console_result_t res;
            int unsigned     i;
            res = '0;
            if (cmd == tccw_pkg::CMD_READ)
            begin
                if (idx < tccw_pkg::CELL_COUNT)
                    res.data = cells[idx];
            end
            else
            begin
                if (ch == tccw_pkg::NEWLINE_CODE)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                else
                begin
                    // The byte goes in unchanged; no sign extension into the attribute.
                    cells[cur_row * tccw_pkg::COLUMNS + cur_col] = {clr, ch};
                    cur_col++;
                end
                if (cur_col >= tccw_pkg::COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= tccw_pkg::ROWS)
                begin
                    for (i = tccw_pkg::COLUMNS; i < tccw_pkg::CELL_COUNT; i++)
                        cells[i - tccw_pkg::COLUMNS] = cells[i];
                    // The whole bottom row is blanked, all columns of it.
                    for (i = 0; i < tccw_pkg::COLUMNS; i++)
                        cells[tccw_pkg::BLANK_START + i] = {blank_attr, tccw_pkg::SPACE_CODE};
                    cur_col      = 0;
                    cur_row      = tccw_pkg::ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            res.col = tccw_pkg::COL_W'(cur_col);
            res.row = tccw_pkg::ROW_W'(cur_row);
            expected_q.push_back(res);
        endfunction

        // Called once per accepted response transaction.
        function void check_response(logic [tccw_pkg::COL_W-1:0] col,
                                     logic [tccw_pkg::ROW_W-1:0] row,
                                     logic [tccw_pkg::CELL_W-1:0] data, logic sc);
            console_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("response with no command outstanding: col %0d row %0d data %h",
                       col, row, data);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (col !== want.col)
            begin
                $error("cursor_col: expected %0d, actual %0d", want.col, col);
                mismatches++;
            end
            if (row !== want.row)
            begin
                $error("cursor_row: expected %0d, actual %0d", want.row, row);
                mismatches++;
            end
            if (data !== want.data)
            begin
                $error("cell_data: expected %h, actual %h", want.data, data);
                mismatches++;
            end
            if (sc !== want.scrolled)
            begin
                $error("scrolled: expected %0d, actual %0d", want.scrolled, sc);
                mismatches++;
            end
        endfunction
    endclass

    logic                          clk              = 1'b0;
    logic                          rst_n            = 1'b0;
    logic                          cfg_write_enable = 1'b0;
    logic [tccw_pkg::BYTE_W-1:0]   cfg_write_data   = '0;
    logic                          cmd_valid        = 1'b0;
    logic                          cmd_stall;
    logic                          command          = tccw_pkg::CMD_PUT;
    logic [tccw_pkg::BYTE_W-1:0]   char_code        = '0;
    logic [tccw_pkg::BYTE_W-1:0]   color            = '0;
    logic [tccw_pkg::INDEX_W-1:0]  read_index       = '0;
    logic                          rsp_valid;
    logic                          rsp_stall        = 1'b0;
    logic [tccw_pkg::COL_W-1:0]    cursor_col;
    logic [tccw_pkg::ROW_W-1:0]    cursor_row;
    logic [tccw_pkg::CELL_W-1:0]   cell_data;
    logic                          scrolled;

    console_scoreboard    board;
    // While calm is set, neither side idles, so transactions go back to back.
    bit                   calm        = 1'b0;
    int                   sent_count  = 0;
    int                   stall_left  = 0;
    int                   flow_left   = 0;
    int                   cycle_count = 0;

    text_console_char_writer_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .command          (command),
        .char_code        (char_code),
        .color            (color),
        .read_index       (read_index),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .cursor_col       (cursor_col),
        .cursor_row       (cursor_row),
        .cell_data        (cell_data),
        .scrolled         (scrolled)
    );

    always #CLK_HALF clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // Reads favor the cursor row and the bottom row, where puts and scrolls leave their
    // marks, and also cover indexes past the end of the grid.
    function automatic logic [tccw_pkg::INDEX_W-1:0] pick_read_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return tccw_pkg::INDEX_W'(board.cur_row * tccw_pkg::COLUMNS
                                      + $urandom_range(0, tccw_pkg::COLUMNS - 1));
        if (r < 55)
            return tccw_pkg::INDEX_W'(tccw_pkg::BLANK_START
                                      + $urandom_range(0, tccw_pkg::COLUMNS - 1));
        if (r < 65)
            return tccw_pkg::INDEX_W'($urandom_range(tccw_pkg::CELL_COUNT,
                                                     2 ** tccw_pkg::INDEX_W - 1));
        return tccw_pkg::INDEX_W'($urandom_range(0, 2 ** tccw_pkg::INDEX_W - 1));
    endfunction

    // Drives one command transaction and waits until the core takes it. Valid stays high
    // into the next transaction when no gap follows, so it is never lowered and raised
    // in the same time step.
    task automatic send_command(input logic cmd, input logic [tccw_pkg::BYTE_W-1:0] ch,
                                input logic [tccw_pkg::BYTE_W-1:0] clr,
                                input logic [tccw_pkg::INDEX_W-1:0] idx);
        int gap;
        command    <= cmd;
        char_code  <= ch;
        color      <= clr;
        read_index <= idx;
        cmd_valid  <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_command(cmd, ch, clr, idx);
        sent_count++;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The index field of a put is ignored, so it carries random bits.
    task automatic put_byte(input logic [tccw_pkg::BYTE_W-1:0] ch,
                            input logic [tccw_pkg::BYTE_W-1:0] clr);
        send_command(tccw_pkg::CMD_PUT, ch, clr,
                     tccw_pkg::INDEX_W'($urandom_range(0, 2 ** tccw_pkg::INDEX_W - 1)));
    endtask

    // The character and color fields of a read are ignored and carry random bits.
    task automatic read_cell(input logic [tccw_pkg::INDEX_W-1:0] idx);
        send_command(tccw_pkg::CMD_READ, tccw_pkg::BYTE_W'($urandom_range(0, 255)),
                     tccw_pkg::BYTE_W'($urandom_range(0, 255)), idx);
    endtask

    // One random stretch of stimulus. Most of it is text shaped like real console output:
    // runs of characters long enough to wrap, runs of newlines that walk the cursor to
    // the bottom and scroll, and reads that look at what was just written.
    task automatic random_burst();
        int kind;
        int len;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            if ($urandom_range(0, 3) == 0)
                read_cell(pick_read_index());
            else if ($urandom_range(0, 9) == 0)
                put_byte(tccw_pkg::NEWLINE_CODE, tccw_pkg::BYTE_W'($urandom_range(0, 255)));
            else
                put_byte(tccw_pkg::BYTE_W'($urandom_range(0, 255)),
                         tccw_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        else if (kind < 65)
        begin
            len = $urandom_range(5, 90);
            for (k = 0; k < len; k++)
                put_byte(tccw_pkg::BYTE_W'($urandom_range(0, 255)),
                         tccw_pkg::BYTE_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0)
                put_byte(tccw_pkg::NEWLINE_CODE, tccw_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        else if (kind < 75)
        begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++)
                put_byte(tccw_pkg::NEWLINE_CODE, tccw_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            len = $urandom_range(1, 4);
            for (k = 0; k < len; k++)
                read_cell(pick_read_index());
        end
    endtask

    // Stops the sender until every outstanding response has come back.
    task automatic drain_responses();
        cmd_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the blank attribute; only called while the core is idle.
    task automatic write_blank_attribute(input logic [tccw_pkg::BYTE_W-1:0] attr);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= attr;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        board.blank_attr = attr;
    endtask

    // Response side: checks every accepted response transaction and stalls at random.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_response(cursor_col, cursor_row, cell_data, scrolled);
        if (calm)
        begin
            rsp_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (flow_left > 0)
        begin
            flow_left--;
            rsp_stall <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            flow_left  = $urandom_range(0, 12);
            rsp_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int                          phase;
        int                          target;
        logic [tccw_pkg::BYTE_W-1:0] attr;
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the blank attribute still at its reset value. The core
        // stalls commands through the clearing sweep, so the first send simply waits.
        read_cell(tccw_pkg::INDEX_W'(0));
        read_cell(tccw_pkg::LAST_CELL);
        read_cell(tccw_pkg::INDEX_W'(tccw_pkg::CELL_COUNT));  // first index past the grid
        read_cell('1);                                        // largest index the field holds
        put_byte(8'h00, 8'h00);
        put_byte(8'hFF, 8'hFF);
        put_byte(8'h80, 8'h7F);                               // high bit set, stored unsigned
        put_byte(8'h7F, 8'h80);
        put_byte(tccw_pkg::NEWLINE_CODE, 8'hFF);
        put_byte(8'h41, 8'h1E);
        read_cell(tccw_pkg::INDEX_W'(0));
        read_cell(tccw_pkg::INDEX_W'(1));
        read_cell(tccw_pkg::INDEX_W'(2));
        read_cell(tccw_pkg::INDEX_W'(3));
        read_cell(tccw_pkg::COLUMNS_IDX);
        read_cell(tccw_pkg::INDEX_W'(tccw_pkg::COLUMNS + 1));
        put_byte(tccw_pkg::NEWLINE_CODE, 8'h00);
        put_byte(tccw_pkg::SPACE_CODE, 8'hA5);
        read_cell(tccw_pkg::INDEX_W'(2 * tccw_pkg::COLUMNS));

        // Random phases, each under its own blank attribute. Every phase opens with a
        // stretch of back-to-back transactions and then turns the idling on.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase > 0)
            begin
                drain_responses();
                case (phase)
                    1:       attr = 8'h00;
                    2:       attr = 8'hFF;
                    3:       attr = tccw_pkg::BYTE_W'($urandom_range(0, 255));
                    default: attr = 8'h5A;
                endcase
                write_blank_attribute(attr);
            end
            calm   = 1'b1;
            target = sent_count + CALM_ITEMS;
            while (sent_count < target)
                random_burst();
            calm   = 1'b0;
            target = sent_count + PHASE_ITEMS - CALM_ITEMS;
            while (sent_count < target)
                random_burst();
        end

        drain_responses();
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
